FILE: src/tip_pkg.sv
// Shared types, codes and constants of the tagged interval profiler.
`timescale 1ns / 1ps
`default_nettype none
package tip_pkg;

  localparam int TS_W       = 63;
  localparam int CNT_W      = 32;
  localparam int TAG_W      = 16;
  localparam int RIDX_W     = 4;
  localparam int OIDX_W     = 4;
  localparam int CMD_W      = 2;
  localparam int STS_W      = 3;

  localparam int IN_TAG_LSB  = 0;
  localparam int IN_TS_LSB   = IN_TAG_LSB + TAG_W;
  localparam int IN_RIDX_LSB = IN_TS_LSB + TS_W;
  localparam int IN_DATA_W   = 88;
  localparam int OUT_DATA_W  = 328;
  localparam int OUT_PAD_W   = OUT_DATA_W - (OIDX_W + 4 + 2 * CNT_W + 4 * TS_W);

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN = 2'd0,
    CMD_END   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK      = 3'd0,
    STS_BEGIN2  = 3'd1,
    STS_END2    = 3'd2,
    STS_IGNORED = 3'd3,
    STS_UNKNOWN = 3'd4,
    STS_FULL    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    MARK_NONE   = 2'd0,
    MARK_BEGIN2 = 2'd1,
    MARK_END2   = 2'd2
  } mark_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_CHECK,
    S_DUR,
    S_TOT,
    S_MAX,
    S_MIN,
    S_WRITE,
    S_TRIM1,
    S_TRIM2,
    S_OUT
  } state_t;

  typedef logic [TS_W-1:0]  ts_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    ts_t   start_ts;
    cnt_t  count;
    ts_t   total;
    ts_t   min_dur;
    ts_t   max_dur;
    logic  in_use;
    mark_t mark;
  } stat_rec_t;

  localparam stat_rec_t REC_RESET = '{
    start_ts: '0,
    count:    '0,
    total:    '0,
    min_dur:  '1,
    max_dur:  '0,
    in_use:   1'b0,
    mark:     MARK_NONE
  };

  typedef struct packed {
    ts_t  value;
    logic flag;
  } alu_res_t;

  typedef struct packed {
    logic done;
    logic hit;
  } scan_res_t;

endpackage
`default_nettype wire

FILE: src/tip_alu.sv
// Shared 63-bit add/subtract unit with saturation and compare flag.
`timescale 1ns / 1ps
`default_nettype none
module tip_alu import tip_pkg::*; (
  input  alu_op_t  op,
  input  ts_t      a,
  input  ts_t      b,
  output alu_res_t res
);

  logic          sub;
  logic [TS_W:0] sum;

  always_comb begin
    sub = (op == ALU_SUB);
    sum = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{TS_W{1'b0}}, sub};
    case (op)
      ALU_SUB: begin
        // flag: a < b, result clamps at zero
        res.flag  = ~sum[TS_W];
        res.value = res.flag ? '0 : sum[TS_W-1:0];
      end
      default: begin
        // flag: overflow, result clamps at all ones
        res.flag  = sum[TS_W];
        res.value = res.flag ? '1 : sum[TS_W-1:0];
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: src/tip_tag_scan.sv
// Tag memory with a sequential lookup over the allocated entries.
`timescale 1ns / 1ps
`default_nettype none
module tip_tag_scan import tip_pkg::*; #(
  parameter  int ENTRIES = 16,
  parameter  int TW      = 16,
  localparam int IW      = $clog2(ENTRIES),
  localparam int UW      = $clog2(ENTRIES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [TW-1:0] tag,
  input  logic [UW-1:0] used,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_idx,
  input  logic [TW-1:0] wr_tag,
  output scan_res_t     res,
  output logic [IW-1:0] hit_idx
);

  logic [TW-1:0] mem [ENTRIES];
  logic [TW-1:0] rdata_r;
  logic          busy_r, busy_nxt;
  logic          pend_r, pend_nxt;
  logic [UW-1:0] ptr_r, ptr_nxt;
  logic [IW-1:0] cidx_r, cidx_nxt;
  logic          match, last, empty, rd_en;

  always_comb begin
    match    = pend_r && (rdata_r == tag);
    last     = pend_r && ((UW'(cidx_r) + UW'(1)) == used);
    empty    = !pend_r && (ptr_r == used);
    res.done = busy_r && (match || last || empty);
    res.hit  = match;
    rd_en    = busy_r && !res.done;

    busy_nxt = busy_r;
    pend_nxt = pend_r;
    ptr_nxt  = ptr_r;
    cidx_nxt = cidx_r;
    if (start) begin
      busy_nxt = 1'b1;
      pend_nxt = 1'b0;
      ptr_nxt  = '0;
    end else if (res.done) begin
      busy_nxt = 1'b0;
      pend_nxt = 1'b0;
    end else if (rd_en) begin
      // compare one entry while the next is read
      pend_nxt = 1'b1;
      cidx_nxt = ptr_r[IW-1:0];
      ptr_nxt  = ptr_r + UW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    cidx_r <= cidx_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_tag;
    end
    if (rd_en) begin
      rdata_r <= mem[ptr_r[IW-1:0]];
    end
  end

  assign hit_idx = cidx_r;

endmodule
`default_nettype wire

FILE: src/tip_stat_ram.sv
// Per-entry statistics memory with valid bits for reset and clear.
`timescale 1ns / 1ps
`default_nettype none
module tip_stat_ram import tip_pkg::*; #(
  parameter  int ENTRIES = 16,
  localparam int IW      = $clog2(ENTRIES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clr,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  stat_rec_t     wdata,
  input  logic          re,
  input  logic [IW-1:0] raddr,
  output stat_rec_t     rdata
);

  stat_rec_t          mem [ENTRIES];
  stat_rec_t          q_r;
  logic               qv_r;
  logic [ENTRIES-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (clr) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv_r <= 1'b0;
    end else if (re) begin
      qv_r <= vld_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q_r <= mem[raddr];
    end
  end

  // unwritten or cleared entries read as fresh statistics
  assign rdata = qv_r ? q_r : REC_RESET;

endmodule
`default_nettype wire

FILE: src/tagged_interval_profiler_top.sv
// Top level of the tagged interval profiler: sequencer and datapath.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------
//  in_     | in  | in_tvalid / in_tready  | tuser: cmd; tdata: tag, timestamp,
//          |     |                        | read_index
//  out_    | out | out_tvalid / out_tready| tuser: status; tdata: entry fields
//
//  One item at a time. Begin/end: accept, scan of the n allocated tags, then as
//  the case needs fetch and check, up to four passes through the shared adder,
//  write-back and two trim passes. Read: fetch, check and two trim passes
//  for a valid index. Clear: accept only. Every item ends in the output step.
//  Reset (rst_n low, synchronous) empties the table via valid bits.
//  A stalled result sits in the output register; the next item is taken while
//  it waits, and the sequencer holds in its last state only if a second
//  result is ready before the first has gone.
`timescale 1ns / 1ps
`default_nettype none
module tagged_interval_profiler_top import tip_pkg::*; #(
  parameter int ENTRIES  = 16,
  parameter int TAG_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [15:0] tag, [78:16] timestamp, [82:79] read_index, [87:83] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] cmd
  input  logic [CMD_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [3:0] entry_index, [4] entry_valid, [6:5] error_mark, [7] in_use,
  // [39:8] call_count, [102:40] total_time, [165:103] min_time,
  // [228:166] max_time, [291:229] trimmed_total, [323:292] trimmed_count,
  // [327:324] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [2:0] status
  output logic [STS_W-1:0]      out_tuser
);

  localparam int TW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int IW = $clog2(ENTRIES);
  localparam int UW = $clog2(ENTRIES + 1);
  localparam int CW = (UW > RIDX_W) ? UW : RIDX_W;

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [TW-1:0]         tag_r, tag_nxt;
  ts_t                   ts_r, ts_nxt;
  logic [RIDX_W-1:0]     ridx_r, ridx_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [UW-1:0]         used_r, used_nxt;
  logic                  ev_r, ev_nxt;
  status_t               status_r, status_nxt;
  stat_rec_t             rec_r, rec_nxt;
  ts_t                   dur_r, dur_nxt;
  ts_t                   trim_r, trim_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [STS_W-1:0]      out_tuser_r, out_tuser_nxt;

  logic                  in_acc;
  cmd_t                  in_cmd;
  logic [RIDX_W-1:0]     in_ridx;
  logic                  rd_ok;
  logic                  full;
  logic                  out_free;
  logic                  scan_start;
  scan_res_t             scan_res;
  logic [IW-1:0]         scan_idx;
  logic                  tag_we;
  logic                  st_we, st_re, st_clr;
  stat_rec_t             st_rdata;
  alu_op_t               alu_op;
  ts_t                   alu_a, alu_b;
  alu_res_t              alu_res;
  logic                  gt2;
  ts_t                   o_ttot;
  cnt_t                  o_tcnt;
  logic [OIDX_W-1:0]     o_idx;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign in_cmd     = cmd_t'(in_tuser);
  assign in_ridx    = in_tdata[IN_RIDX_LSB +: RIDX_W];
  assign rd_ok      = (CW'(in_ridx) < CW'(used_r));
  assign full       = (used_r == UW'(ENTRIES));
  assign out_free   = !out_valid_r || out_tready;
  assign scan_start = in_acc && ((in_cmd == CMD_BEGIN) || (in_cmd == CMD_END));

  tip_tag_scan #(
    .ENTRIES (ENTRIES),
    .TW      (TW)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .tag     (tag_r),
    .used    (used_r),
    .wr_en   (tag_we),
    .wr_idx  (idx_nxt),
    .wr_tag  (tag_r),
    .res     (scan_res),
    .hit_idx (scan_idx)
  );

  tip_stat_ram #(
    .ENTRIES (ENTRIES)
  ) u_stat (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (st_clr),
    .we    (st_we),
    .waddr (idx_r),
    .wdata (rec_r),
    .re    (st_re),
    .raddr (idx_r),
    .rdata (st_rdata)
  );

  tip_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_BEGIN, CMD_END: state_nxt = S_SCAN;
            CMD_READ:           state_nxt = rd_ok ? S_FETCH : S_OUT;
            default:            state_nxt = S_OUT;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_res.done) begin
          if (scan_res.hit) begin
            state_nxt = S_FETCH;
          end else if ((cmd_r == CMD_BEGIN) && !full) begin
            state_nxt = S_WRITE;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_FETCH: state_nxt = S_CHECK;
      S_CHECK: begin
        case (cmd_r)
          CMD_BEGIN: begin
            if (!st_rdata.in_use && (st_rdata.mark == MARK_END2)) begin
              state_nxt = S_TRIM1;
            end else begin
              state_nxt = S_WRITE;
            end
          end
          CMD_END: begin
            if (!st_rdata.in_use) begin
              state_nxt = S_WRITE;
            end else if (st_rdata.mark == MARK_BEGIN2) begin
              state_nxt = S_TRIM1;
            end else begin
              state_nxt = S_DUR;
            end
          end
          default: state_nxt = S_TRIM1;
        endcase
      end
      S_DUR:   state_nxt = S_TOT;
      S_TOT:   state_nxt = S_MAX;
      S_MAX:   state_nxt = S_MIN;
      S_MIN:   state_nxt = S_WRITE;
      S_WRITE: state_nxt = S_TRIM1;
      S_TRIM1: state_nxt = S_TRIM2;
      S_TRIM2: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output fields of the result
  always_comb begin
    gt2    = (rec_r.count > CNT_W'(2));
    o_ttot = gt2 ? trim_r : rec_r.total;
    o_tcnt = gt2 ? (rec_r.count - CNT_W'(2)) : rec_r.count;
    o_idx  = ev_r ? OIDX_W'(idx_r) : ((cmd_r == CMD_READ) ? ridx_r : '0);
  end

  // datapath and strobes
  always_comb begin
    cmd_nxt       = cmd_r;
    tag_nxt       = tag_r;
    ts_nxt        = ts_r;
    ridx_nxt      = ridx_r;
    idx_nxt       = idx_r;
    used_nxt      = used_r;
    ev_nxt        = ev_r;
    status_nxt    = status_r;
    rec_nxt       = rec_r;
    dur_nxt       = dur_r;
    trim_nxt      = trim_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_tdata_nxt = out_tdata_r;
    out_tuser_nxt = out_tuser_r;
    tag_we        = 1'b0;
    st_we         = 1'b0;
    st_re         = 1'b0;
    st_clr        = 1'b0;
    alu_op        = ALU_SUB;
    alu_a         = rec_r.total;
    alu_b         = rec_r.min_dur;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt    = in_cmd;
          tag_nxt    = in_tdata[IN_TAG_LSB +: TW];
          ts_nxt     = in_tdata[IN_TS_LSB +: TS_W];
          ridx_nxt   = in_ridx;
          status_nxt = STS_OK;
          ev_nxt     = 1'b0;
          if (in_cmd == CMD_READ) begin
            ev_nxt  = rd_ok;
            idx_nxt = IW'(in_ridx);
          end
          if (in_cmd == CMD_CLEAR) begin
            st_clr = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (scan_res.done) begin
          if (scan_res.hit) begin
            idx_nxt = scan_idx;
            ev_nxt  = 1'b1;
          end else if ((cmd_r == CMD_BEGIN) && !full) begin
            idx_nxt          = IW'(used_r);
            tag_we           = 1'b1;
            used_nxt         = used_r + UW'(1);
            rec_nxt          = REC_RESET;
            rec_nxt.start_ts = ts_r;
            rec_nxt.in_use   = 1'b1;
            ev_nxt           = 1'b1;
          end else begin
            status_nxt = (cmd_r == CMD_BEGIN) ? STS_FULL : STS_UNKNOWN;
            ev_nxt     = 1'b0;
          end
        end
      end
      S_FETCH: st_re = 1'b1;
      S_CHECK: begin
        rec_nxt = st_rdata;
        case (cmd_r)
          CMD_BEGIN: begin
            if (st_rdata.in_use) begin
              rec_nxt.mark = MARK_BEGIN2;
              status_nxt   = STS_BEGIN2;
            end else if (st_rdata.mark == MARK_END2) begin
              status_nxt = STS_IGNORED;
            end else begin
              rec_nxt.start_ts = ts_r;
              rec_nxt.in_use   = 1'b1;
            end
          end
          CMD_END: begin
            if (!st_rdata.in_use) begin
              rec_nxt.mark = MARK_END2;
              status_nxt   = STS_END2;
            end else if (st_rdata.mark == MARK_BEGIN2) begin
              status_nxt = STS_IGNORED;
            end
          end
          default: status_nxt = STS_OK;
        endcase
      end
      S_DUR: begin
        alu_a   = ts_r;
        alu_b   = rec_r.start_ts;
        dur_nxt = alu_res.value;
      end
      S_TOT: begin
        alu_op        = ALU_ADD;
        alu_a         = rec_r.total;
        alu_b         = dur_r;
        rec_nxt.total = alu_res.value;
        if (rec_r.count != '1) begin
          rec_nxt.count = rec_r.count + CNT_W'(1);
        end
      end
      S_MAX: begin
        alu_a = rec_r.max_dur;
        alu_b = dur_r;
        if (alu_res.flag) begin
          rec_nxt.max_dur = dur_r;
        end
      end
      S_MIN: begin
        alu_a = dur_r;
        alu_b = rec_r.min_dur;
        if (alu_res.flag) begin
          rec_nxt.min_dur = dur_r;
        end
        rec_nxt.in_use = 1'b0;
      end
      S_WRITE: st_we = 1'b1;
      S_TRIM1: begin
        alu_a    = rec_r.total;
        alu_b    = rec_r.min_dur;
        trim_nxt = alu_res.value;
      end
      S_TRIM2: begin
        alu_a    = trim_r;
        alu_b    = rec_r.max_dur;
        trim_nxt = alu_res.value;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_tuser_nxt = status_r;
          if (ev_r) begin
            out_tdata_nxt = {{OUT_PAD_W{1'b0}}, o_tcnt, o_ttot, rec_r.max_dur,
                             rec_r.min_dur, rec_r.total, rec_r.count,
                             rec_r.in_use, rec_r.mark, 1'b1, o_idx};
          end else begin
            out_tdata_nxt = {{(OUT_DATA_W - OIDX_W){1'b0}}, o_idx};
          end
        end
      end
      default: status_nxt = status_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    tag_r       <= tag_nxt;
    ts_r        <= ts_nxt;
    ridx_r      <= ridx_nxt;
    idx_r       <= idx_nxt;
    ev_r        <= ev_nxt;
    status_r    <= status_nxt;
    rec_r       <= rec_nxt;
    dur_r       <= dur_nxt;
    trim_r      <= trim_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(ENTRIES))
    else $error("allocation count beyond table size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("second item taken while one is in work");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside the output step");

  a_write_allocated: assert property (@(posedge clk) disable iff (!rst_n)
    st_we |-> (UW'(idx_r) < used_r))
    else $error("statistics written to an unallocated entry");

  a_scan_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    scan_res.done |-> (state_r == S_SCAN))
    else $error("tag lookup finished outside the lookup step");

endmodule
`default_nettype wire
